>>> rtl/core/wpl_pkg.sv
// ----------------------------------------------------------------------------
// wpl_pkg
// Shared widths, reset values and controller/datapath signal groups for the
// weighted 3D path length block.
// ----------------------------------------------------------------------------
package wpl_pkg;

  localparam int COORD_W    = 24;
  localparam int FACTOR_W   = 12;
  localparam int SEG_W      = 27;
  localparam int TOTAL_W    = 48;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int PROD_W     = ROOT_W + FACTOR_W;
  localparam int NUM_AXES   = 3;
  localparam int CNT_W      = $clog2(ROOT_STEPS);

  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic [FACTOR_W-1:0] DESCENT_RESET = FACTOR_W'(384);
  localparam logic [FACTOR_W-1:0] ASCENT_RESET  = FACTOR_W'(205);
  localparam logic [FACTOR_W-1:0] UNITY         = FACTOR_W'(256);
  localparam logic [SEG_W-1:0]    SEG_MAX       = {SEG_W{1'b1}};
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX     = {TOTAL_W{1'b1}};

  // register indexes
  localparam logic REG_DESCENT = 1'b0;
  localparam logic REG_ASCENT  = 1'b1;

  // axis selects for the shared squarer
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic       root_step;
    logic       scale;
    logic       round;
    logic       accum;
    logic       load_out;
  } wpl_cmd_t;

  typedef struct packed {
    logic out_free;
  } wpl_status_t;

endpackage

>>> rtl/core/wpl_pt_if.sv
// ----------------------------------------------------------------------------
// wpl_pt_if
// Point channel: valid/ready handshake with one path point per item.
// ----------------------------------------------------------------------------
interface wpl_pt_if;
  logic                               valid;
  logic                               ready;
  logic signed [wpl_pkg::COORD_W-1:0] coord_x;
  logic signed [wpl_pkg::COORD_W-1:0] coord_y;
  logic signed [wpl_pkg::COORD_W-1:0] coord_z;
  logic                               path_start;
  logic                               path_last;

  modport source (
    output valid, coord_x, coord_y, coord_z, path_start, path_last,
    input  ready
  );
  modport sink (
    input  valid, coord_x, coord_y, coord_z, path_start, path_last,
    output ready
  );
endinterface

>>> rtl/core/wpl_res_if.sv
// ----------------------------------------------------------------------------
// wpl_res_if
// Result channel: valid/ready handshake with one cost item per point.
// ----------------------------------------------------------------------------
interface wpl_res_if;
  logic                         valid;
  logic                         ready;
  logic [wpl_pkg::SEG_W-1:0]    segment_cost;
  logic [wpl_pkg::TOTAL_W-1:0]  total_cost;
  logic                         path_end;

  modport source (
    output valid, segment_cost, total_cost, path_end,
    input  ready
  );
  modport sink (
    input  valid, segment_cost, total_cost, path_end,
    output ready
  );
endinterface

>>> rtl/core/wpl_ctrl.sv
// ----------------------------------------------------------------------------
// wpl_ctrl
// Sequencer: takes a point, steps the shared squarer, the root iterations,
// scaling, rounding and accumulation, then hands the result to the output.
// ----------------------------------------------------------------------------
module wpl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pt_valid,
  output logic                 pt_ready,
  input  wpl_pkg::wpl_status_t status,
  output wpl_pkg::wpl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_ROOT   = 3'd2;
  localparam logic [2:0] S_SCALE  = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_ACCUM  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [wpl_pkg::CNT_W-1:0] SQ_LAST   = wpl_pkg::CNT_W'(wpl_pkg::NUM_AXES);
  localparam logic [wpl_pkg::CNT_W-1:0] ROOT_LAST =
    wpl_pkg::CNT_W'(wpl_pkg::ROOT_STEPS - 1);

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [wpl_pkg::CNT_W-1:0] cnt;
  logic [wpl_pkg::CNT_W-1:0] cnt_next;

  assign pt_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (pt_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SQUARE;
          cnt_next    = '0;
        end
      end
      S_SQUARE: begin
        // square one axis a cycle, add the previous square behind it
        cmd.mul_en  = (cnt < SQ_LAST);
        cmd.mul_sel = cnt[1:0];
        cmd.acc_en  = (cnt != '0);
        if (cnt == SQ_LAST) begin
          state_next = S_ROOT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == ROOT_LAST) begin
          state_next = S_SCALE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

>>> rtl/core/wpl_dp.sv
// ----------------------------------------------------------------------------
// wpl_dp
// Datapath: coordinate differences, shared squarer, bit-serial square root,
// factor scaling with rounding, saturating total and the output register.
// ----------------------------------------------------------------------------
module wpl_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  wpl_pkg::wpl_cmd_t                   cmd,
  output wpl_pkg::wpl_status_t                status,
  input  logic signed [wpl_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [wpl_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [wpl_pkg::COORD_W-1:0]  coord_z,
  input  logic                                path_start,
  input  logic                                path_last,
  input  logic [wpl_pkg::FACTOR_W-1:0]        descent_factor,
  input  logic [wpl_pkg::FACTOR_W-1:0]        ascent_factor,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [wpl_pkg::SEG_W-1:0]           segment_cost,
  output logic [wpl_pkg::TOTAL_W-1:0]         total_cost,
  output logic                                path_end
);

  // previous point and running total
  logic signed [wpl_pkg::COORD_W-1:0] prev_x;
  logic signed [wpl_pkg::COORD_W-1:0] prev_y;
  logic signed [wpl_pkg::COORD_W-1:0] prev_z;
  logic [wpl_pkg::TOTAL_W-1:0]        running_total;

  // item under work
  logic [wpl_pkg::MAG_W-1:0]  mag_x;
  logic [wpl_pkg::MAG_W-1:0]  mag_y;
  logic [wpl_pkg::MAG_W-1:0]  mag_z;
  logic                       going_down;
  logic                       going_up;
  logic                       item_start;
  logic                       item_last;
  logic [wpl_pkg::SQ_W-1:0]   sq;
  logic [wpl_pkg::SUM_W-1:0]  sum;
  logic [wpl_pkg::REM_W-1:0]  rem;
  logic [wpl_pkg::ROOT_W-1:0] root;
  logic [wpl_pkg::PROD_W-1:0] prod;
  logic [wpl_pkg::SEG_W-1:0]  cost;

  logic signed [wpl_pkg::DIFF_W-1:0] dx;
  logic signed [wpl_pkg::DIFF_W-1:0] dy;
  logic signed [wpl_pkg::DIFF_W-1:0] dz;
  logic [wpl_pkg::DIFF_W-1:0]        ax;
  logic [wpl_pkg::DIFF_W-1:0]        ay;
  logic [wpl_pkg::DIFF_W-1:0]        az;
  logic [wpl_pkg::MAG_W-1:0]         mul_mag;
  logic [wpl_pkg::REM_W+1:0]         rem_sh;
  logic [wpl_pkg::REM_W+1:0]         trial;
  logic [wpl_pkg::FACTOR_W-1:0]      factor;
  logic [wpl_pkg::PROD_W:0]          rounded;
  logic [wpl_pkg::PROD_W-8:0]        scaled;
  logic [wpl_pkg::TOTAL_W:0]         total_sum;

  function automatic logic signed [wpl_pkg::DIFF_W-1:0] DIFF_W_EXT(
    input logic signed [wpl_pkg::COORD_W-1:0] v
  );
    return {v[wpl_pkg::COORD_W-1], v};
  endfunction

  assign dx = DIFF_W_EXT(coord_x) - DIFF_W_EXT(prev_x);
  assign dy = DIFF_W_EXT(coord_y) - DIFF_W_EXT(prev_y);
  assign dz = DIFF_W_EXT(coord_z) - DIFF_W_EXT(prev_z);
  assign ax = dx[wpl_pkg::DIFF_W-1] ? -dx : dx;
  assign ay = dy[wpl_pkg::DIFF_W-1] ? -dy : dy;
  assign az = dz[wpl_pkg::DIFF_W-1] ? -dz : dz;

  always_comb begin
    case (cmd.mul_sel)
      wpl_pkg::AXIS_X: mul_mag = mag_x;
      wpl_pkg::AXIS_Y: mul_mag = mag_y;
      wpl_pkg::AXIS_Z: mul_mag = mag_z;
      default:         mul_mag = '0;
    endcase
  end

  // one root bit a step: bring down the next two bits of the sum
  assign rem_sh = {rem, sum[wpl_pkg::SUM_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};

  always_comb begin
    if (going_down) begin
      factor = descent_factor;
    end else if (going_up) begin
      factor = ascent_factor;
    end else begin
      factor = wpl_pkg::UNITY;
    end
  end

  assign rounded   = {1'b0, prod} + (wpl_pkg::PROD_W + 1)'(128);
  assign scaled    = rounded[wpl_pkg::PROD_W:8];
  assign total_sum = {1'b0, running_total} + (wpl_pkg::TOTAL_W + 1)'(cost);

  assign status.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag_x      <= ax[wpl_pkg::MAG_W-1:0];
      mag_y      <= ay[wpl_pkg::MAG_W-1:0];
      mag_z      <= az[wpl_pkg::MAG_W-1:0];
      going_down <= coord_z < prev_z;
      going_up   <= coord_z > prev_z;
      item_start <= path_start;
      item_last  <= path_last;
      sum        <= '0;
      rem        <= '0;
      root       <= '0;
    end else if (cmd.root_step) begin
      sum <= {sum[wpl_pkg::SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= wpl_pkg::REM_W'(rem_sh - trial);
        root <= {root[wpl_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[wpl_pkg::REM_W-1:0];
        root <= {root[wpl_pkg::ROOT_W-2:0], 1'b0};
      end
    end else if (cmd.acc_en) begin
      sum <= sum + wpl_pkg::SUM_W'(sq);
    end
    if (cmd.mul_en) begin
      sq <= mul_mag * mul_mag;
    end
    if (cmd.scale) begin
      prod <= wpl_pkg::PROD_W'(root) * wpl_pkg::PROD_W'(factor);
    end
    if (cmd.round) begin
      if (item_start) begin
        cost <= '0;
      end else if (scaled > wpl_pkg::SEG_MAX) begin
        cost <= wpl_pkg::SEG_MAX;
      end else begin
        cost <= scaled[wpl_pkg::SEG_W-1:0];
      end
    end
    if (cmd.load_out) begin
      segment_cost <= cost;
      total_cost   <= running_total;
      path_end     <= item_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x        <= '0;
      prev_y        <= '0;
      prev_z        <= '0;
      running_total <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        prev_x <= coord_x;
        prev_y <= coord_y;
        prev_z <= coord_z;
      end
      if (cmd.accum) begin
        if (item_start) begin
          running_total <= '0;
        end else if (total_sum[wpl_pkg::TOTAL_W]) begin
          running_total <= wpl_pkg::TOTAL_MAX;
        end else begin
          running_total <= total_sum[wpl_pkg::TOTAL_W-1:0];
        end
      end
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/weighted_path_length_3d.sv
// ----------------------------------------------------------------------------
// weighted_path_length_3d
// Weighted Euclidean length of a 3D path, one point per item.
// ----------------------------------------------------------------------------
// Points arrive on pt (valid/ready) as signed Q15.8 x, y, z with path_start
// and path_last marks; each point yields one item on res carrying the
// weighted segment cost, the saturating running total and the end mark.
// descent_factor (address 0) and ascent_factor (address 4) are Q4.8 and are
// written through the APB port; pready is tied high.
// From acceptance to a valid result, a point passes through the shared
// squarer, the bit-serial square root of the 50-bit sum of squares,
// scaling, rounding, accumulation and the load of the output register.
// The sequencer returns to idle on that load, so a new point is taken only
// after it; the root iteration dominates.
// A point is taken only while no other point is at work; a finished result
// waits in the output register, and the next point may be accepted while it
// waits. If res stalls, the following result holds in the sequencer until
// the output register frees.
// Reset clears the previous point to the origin, the total to zero and the
// factors to 1.5 and about 0.8; no result is pending after reset.
// ----------------------------------------------------------------------------
module weighted_path_length_3d (
  input  logic                         clk,
  input  logic                         rst,
  wpl_pt_if.sink                       pt,
  wpl_res_if.source                    res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wpl_pkg::APB_AW-1:0]   paddr,
  input  logic [wpl_pkg::APB_DW-1:0]   pwdata,
  output logic [wpl_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  logic [wpl_pkg::FACTOR_W-1:0] descent_factor;
  logic [wpl_pkg::FACTOR_W-1:0] ascent_factor;
  wpl_pkg::wpl_cmd_t            cmd;
  wpl_pkg::wpl_status_t         status;
  logic                         reg_index;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      descent_factor <= wpl_pkg::DESCENT_RESET;
      ascent_factor  <= wpl_pkg::ASCENT_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        wpl_pkg::REG_DESCENT: descent_factor <= pwdata[wpl_pkg::FACTOR_W-1:0];
        wpl_pkg::REG_ASCENT:  ascent_factor  <= pwdata[wpl_pkg::FACTOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      wpl_pkg::REG_DESCENT: prdata = wpl_pkg::APB_DW'(descent_factor);
      wpl_pkg::REG_ASCENT:  prdata = wpl_pkg::APB_DW'(ascent_factor);
      default:              prdata = '0;
    endcase
  end

  wpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .pt_valid (pt.valid),
    .pt_ready (pt.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wpl_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .coord_x        (pt.coord_x),
    .coord_y        (pt.coord_y),
    .coord_z        (pt.coord_z),
    .path_start     (pt.path_start),
    .path_last      (pt.path_last),
    .descent_factor (descent_factor),
    .ascent_factor  (ascent_factor),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .segment_cost   (res.segment_cost),
    .total_cost     (res.total_cost),
    .path_end       (res.path_end)
  );

endmodule

>>> tb/path_cost_checker.sv
// ----------------------------------------------------------------------------
// path_cost_checker
// Watches the point and result channels of the weighted path length block,
// predicts the cost of every accepted point and compares each result with it.
// Factor writes are followed on the APB port, so the prediction uses the
// factors that the block holds. Mismatches are counted and passed up.
// ----------------------------------------------------------------------------
module path_cost_checker (
  input  logic                         clk,
  input  logic                         rst,
  wpl_pt_if                            pt,
  wpl_res_if                           res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [wpl_pkg::APB_AW-1:0]   paddr,
  input  logic [wpl_pkg::APB_DW-1:0]   pwdata,
  output int                           fail_count,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wpl_pkg::*;

  typedef struct packed {
    logic [SEG_W-1:0]   segment_cost;
    logic [TOTAL_W-1:0] total_cost;
    logic               path_end;
  } cost_item_t;

  logic [FACTOR_W-1:0]       fall_factor;
  logic [FACTOR_W-1:0]       rise_factor;
  logic signed [COORD_W-1:0] last_x;
  logic signed [COORD_W-1:0] last_y;
  logic signed [COORD_W-1:0] last_z;
  logic [TOTAL_W-1:0]        path_total;
  cost_item_t                costs_due[$];
  cost_item_t                want;
  cost_item_t                got;
  int                        mismatches = 0;

  // digit-by-digit floor square root
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = n;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // cost one point and advance the stored path
  function automatic cost_item_t cost_of_point(input logic signed [COORD_W-1:0] x, y, z,
                                               input logic start, last);
    longint              dx;
    longint              dy;
    longint              dz;
    logic [63:0]         seg_len;
    logic [63:0]         cost;
    logic [63:0]         sum;
    logic [FACTOR_W-1:0] factor;
    cost_item_t          r;
    cost = '0;
    if (start) begin
      path_total = '0;
    end else begin
      dx      = longint'(x) - longint'(last_x);
      dy      = longint'(y) - longint'(last_y);
      dz      = longint'(z) - longint'(last_z);
      seg_len = floor_root(64'(dx * dx + dy * dy + dz * dz));
      if (z < last_z) factor = fall_factor;
      else if (z > last_z) factor = rise_factor;
      else factor = UNITY;
      cost = (seg_len * 64'(factor) + 64'd128) >> 8;
      if (cost > 64'(SEG_MAX)) cost = 64'(SEG_MAX);
    end
    sum = 64'(path_total) + cost;
    if (sum > 64'(TOTAL_MAX)) sum = 64'(TOTAL_MAX);
    path_total = sum[TOTAL_W-1:0];
    last_x = x;
    last_y = y;
    last_z = z;
    r.segment_cost = cost[SEG_W-1:0];
    r.total_cost   = path_total;
    r.path_end     = last;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fall_factor = DESCENT_RESET;
      rise_factor = ASCENT_RESET;
      last_x      = '0;
      last_y      = '0;
      last_z      = '0;
      path_total  = '0;
      costs_due.delete();
    end else begin
      if (res.valid && res.ready) begin
        got.segment_cost = res.segment_cost;
        got.total_cost   = res.total_cost;
        got.path_end     = res.path_end;
        if (costs_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no point waiting: segment %0d total %0d end %0b",
                     $time, got.segment_cost, got.total_cost, got.path_end);
          mismatches++;
        end else begin
          want = costs_due.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display("%0t: cost mismatch: segment exp %0d act %0d, total exp %0d act %0d, %s",
                       $time, want.segment_cost, got.segment_cost, want.total_cost,
                       got.total_cost, $sformatf("end exp %0b act %0b",
                       want.path_end, got.path_end));
            mismatches++;
          end
        end
      end
      if (pt.valid && pt.ready)
        costs_due.insert(costs_due.size(),
                         cost_of_point(pt.coord_x, pt.coord_y, pt.coord_z,
                                       pt.path_start, pt.path_last));
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1] == REG_ASCENT) rise_factor = pwdata[FACTOR_W-1:0];
        else fall_factor = pwdata[FACTOR_W-1:0];
      end
    end
    pending    <= costs_due.size();
    fail_count <= mismatches;
  end

endmodule

>>> tb/weighted_path_length_3d_tb.sv
// ----------------------------------------------------------------------------
// weighted_path_length_3d_tb
// Drives points and factor writes into the weighted path length block.
// A directed set covers the coordinate extremes, climbs, drops, level moves,
// saturation and the path marks; random paths follow under several factor
// settings with random idling on both channels. The checker beside the block
// predicts every result; the verdict comes from its failure count.
// ----------------------------------------------------------------------------
module weighted_path_length_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wpl_pkg::*;

  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 200;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;
  bit                calm = 1'b0;
  bit                long_hold = 1'b0;
  bit                hold_done = 1'b0;

  wpl_pt_if  pt_ch ();
  wpl_res_if res_ch ();

  weighted_path_length_3d uut (
    .clk     (clk),
    .rst     (rst),
    .pt      (pt_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  path_cost_checker chk (
    .clk        (clk),
    .rst        (rst),
    .pt         (pt_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one point, hold it until taken, then maybe leave a gap
  task automatic push_point(input coord_t x, y, z, input logic start, last);
    pt_ch.valid      <= 1'b1;
    pt_ch.coord_x    <= x;
    pt_ch.coord_y    <= y;
    pt_ch.coord_z    <= z;
    pt_ch.path_start <= start;
    pt_ch.path_last  <= last;
    do @(posedge clk); while (!pt_ch.ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    pt_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_write(input logic idx, input logic [FACTOR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_factors(input logic [FACTOR_W-1:0] fall, rise);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_DESCENT, fall);
    apb_write(REG_ASCENT, rise);
  endtask

  function automatic coord_t next_coord(input coord_t prev);
    case ($urandom_range(0, 7))
      0, 1:    return coord_t'($urandom());
      2:       return prev;
      3:       return prev + coord_t'($urandom_range(0, 1 << 17)) - coord_t'(1 << 16);
      default: return prev + coord_t'($urandom_range(0, 8192)) - coord_t'(4096);
    endcase
  endfunction

  // mostly well-formed paths of random length, some with broken marks
  task automatic random_phase(input int n_items);
    int     left;
    int     len;
    int     k;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   start;
    logic   last;
    x    = coord_t'($urandom());
    y    = coord_t'($urandom());
    z    = coord_t'($urandom());
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if ($urandom_range(0, 40) == 0) wait_drained();
      for (k = 0; k < len && left > 0; k++) begin
        x = next_coord(x);
        y = next_coord(y);
        z = ($urandom_range(0, 3) == 0) ? z : next_coord(z);
        start = (k == 0);
        last  = (k == len - 1) || (left == 1);
        if ($urandom_range(0, 9) == 0) begin
          start = 1'($urandom_range(0, 1));
          last  = 1'($urandom_range(0, 1));
        end
        push_point(x, y, z, start, last);
        left--;
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold && !hold_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int phase;
    rst              <= 1'b1;
    pt_ch.valid      <= 1'b0;
    pt_ch.coord_x    <= '0;
    pt_ch.coord_y    <= '0;
    pt_ch.coord_z    <= '0;
    pt_ch.path_start <= 1'b0;
    pt_ch.path_last  <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset factors; the first point is costed from the origin
    push_point(24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0);
    push_point(24'sd256, 24'sd0, 24'sd0, 1'b0, 1'b0);
    push_point(24'sd256, 24'sd0, 24'sd128, 1'b0, 1'b0);
    push_point(24'sd100, -24'sd200, 24'sd300, 1'b0, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    push_point(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    push_point(24'sd0, 24'sd0, COORD_MAX, 1'b0, 1'b1);
    // no start after the last point: the total carries on
    push_point(24'sd5, 24'sd5, 24'sd5, 1'b0, 1'b0);
    push_point(24'sd7, 24'sd7, 24'sd7, 1'b1, 1'b1);
    push_point(-24'sd1, -24'sd1, -24'sd1, 1'b0, 1'b0);
    push_point(24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b1);

    // steepest drop saturates the segment cost
    set_factors(12'd4095, 12'd0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    push_point(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
    push_point(24'sd0, 24'sd0, COORD_MAX, 1'b0, 1'b1);

    set_factors(12'd0, 12'd4095);
    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    push_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, 1'b1);

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_factors(UNITY, UNITY);
        1: begin
          set_factors(FACTOR_W'($urandom_range(0, 4095)), FACTOR_W'($urandom_range(0, 4095)));
          long_hold = 1'b1;
        end
        2: set_factors(12'd4095, 12'd4095);
        3: set_factors(12'd0, 12'd0);
        default: begin
          set_factors(FACTOR_W'($urandom_range(0, 4095)), FACTOR_W'($urandom_range(0, 4095)));
          calm = 1'b1;
        end
      endcase
      random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
